[rtl/bbsf_pkg.sv]
`default_nettype none
package bbsf_pkg;

  // Field widths
  localparam int CMD_W  = 3;
  localparam int BYTE_W = 8;
  localparam int RUN_W  = 7;
  localparam int CAP_W  = 9;
  localparam int TOT_W  = 32;

  // Default sizing
  localparam int DEF_DEPTH   = 256;
  localparam int DEF_MAX_RUN = 64;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_END   = 3'd4;

  // Stream status carried on every result word
  typedef struct packed {
    logic             error_flag;
    logic [CAP_W-1:0] buffered;
    logic [CAP_W-1:0] space_left;
    logic             ended;
    logic             at_eof;
    logic [TOT_W-1:0] total_written;
    logic [TOT_W-1:0] total_read;
  } stat_t;

endpackage
`default_nettype wire

[rtl/bbsf_in_if.sv]
`default_nettype none
interface bbsf_in_if;
  import bbsf_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] data_in;
  logic [RUN_W-1:0]  run_length;

  modport source (output valid, cmd, data_in, run_length, input ready);
  modport sink   (input valid, cmd, data_in, run_length, output ready);
endinterface
`default_nettype wire

[rtl/bbsf_out_if.sv]
`default_nettype none
interface bbsf_out_if;
  import bbsf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_out;
  logic              data_valid;
  logic              last;
  logic              accepted;
  logic              error_flag;
  logic [CAP_W-1:0]  buffered;
  logic [CAP_W-1:0]  space_left;
  logic              ended;
  logic              at_eof;
  logic [TOT_W-1:0]  total_written;
  logic [TOT_W-1:0]  total_read;

  modport source (output valid, data_out, data_valid, last, accepted, error_flag, buffered,
                  space_left, ended, at_eof, total_written, total_read, input ready);
  modport sink   (input valid, data_out, data_valid, last, accepted, error_flag, buffered,
                  space_left, ended, at_eof, total_written, total_read, output ready);
endinterface
`default_nettype wire

[rtl/bbsf_ram.sv]
`default_nettype none
module bbsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/bounded_byte_stream_fifo_top.sv]
`default_nettype none
// Bounded byte FIFO with an end-of-input mark. Each input word carries one command: write a
// byte, read a run, pop a run, peek a run or end input. Writes, pops, end input and refused or
// erroneous commands give one result word each and stream at one per cycle while the result
// side keeps up. A read or peek of n bytes gives n result words: the bytes come one per cycle,
// while the result side keeps up, from the single registered read port of the byte memory; the
// next command is taken once the last byte is in the output register. Runs are capped at
// MAX_RUN bytes. The effective capacity is the smaller of the capacity register (reset 256) and
// DEPTH; write the capacity only while the block is idle.
// Every result word reports the stream status as it stands after its command. The byte memory
// needs no clearing after reset: only written bytes are ever read.
module bounded_byte_stream_fifo_top #(
  parameter int DEPTH   = bbsf_pkg::DEF_DEPTH,
  parameter int MAX_RUN = bbsf_pkg::DEF_MAX_RUN
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [bbsf_pkg::CAP_W-1:0] cfg_wdata,
  bbsf_in_if.sink                         in_ch,
  bbsf_out_if.source                      out_ch
);
  import bbsf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = ((AW > CAP_W) ? AW : CAP_W) + 1;
  localparam logic [CAP_W-1:0] DEPTH_CAP = (DEPTH > 511) ? 9'd511 : CAP_W'(DEPTH);
  localparam logic [SW-1:0]    DEPTH_S   = SW'(DEPTH);
  localparam logic [RUN_W-1:0] RUN_MAX   = RUN_W'(MAX_RUN);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // Control and stream state
  logic             state_r, state_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [CAP_W-1:0] fill_r, fill_nxt;
  logic             done_r, done_nxt;
  logic             err_r, err_nxt;
  logic [TOT_W-1:0] wtot_r, wtot_nxt;
  logic [TOT_W-1:0] rtot_r, rtot_nxt;
  logic [CAP_W-1:0] cap_r;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [RUN_W-1:0] left_r, left_nxt;

  // Output register
  logic              ovalid_r, ovalid_nxt;
  logic [BYTE_W-1:0] odata_r, odata_nxt;
  logic              odv_r, odv_nxt;
  logic              olast_r, olast_nxt;
  logic              oacc_r, oacc_nxt;
  stat_t             ostat_r, ostat_nxt;

  // Memory port signals
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic             slot_free;
  logic             accept;
  logic [RUN_W-1:0] run_sat;
  logic [CAP_W-1:0] run_ext;
  logic [CAP_W-1:0] eff_cap;
  logic [SW-1:0]    wsum;
  logic [SW-1:0]    psum;
  logic [RUN_W-1:0] peek_n;
  logic             multi;
  logic             acc;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic stat_t make_stat(input logic [CAP_W-1:0] fill,
                                      input logic             done,
                                      input logic             err,
                                      input logic [TOT_W-1:0] wtot,
                                      input logic [TOT_W-1:0] rtot,
                                      input logic [CAP_W-1:0] cap);
    stat_t s;
    s.error_flag    = err;
    s.buffered      = fill;
    s.space_left    = (cap > fill) ? cap - fill : '0;
    s.ended         = done;
    s.at_eof        = done && (fill == '0);
    s.total_written = wtot;
    s.total_read    = rtot;
    make_stat = s;
  endfunction

  bbsf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.data_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign eff_cap   = (cap_r < DEPTH_CAP) ? cap_r : DEPTH_CAP;
  assign slot_free = !ovalid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && slot_free;
  assign accept    = in_ch.valid && in_ch.ready;
  assign run_sat   = (in_ch.run_length > RUN_MAX) ? RUN_MAX : in_ch.run_length;
  assign run_ext   = CAP_W'(run_sat);
  assign peek_n    = (run_ext < fill_r) ? run_sat : RUN_W'(fill_r);

  // Tail address and new head after a removal, both below twice the depth
  assign wsum      = SW'(head_r) + SW'(fill_r);
  assign psum      = SW'(head_r) + SW'(run_sat);
  assign ram_waddr = (wsum >= DEPTH_S) ? AW'(wsum - DEPTH_S) : AW'(wsum);

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    done_nxt  = done_r;
    err_nxt   = err_r;
    wtot_nxt  = wtot_r;
    rtot_nxt  = rtot_r;
    ptr_nxt   = ptr_r;
    left_nxt  = left_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = head_r;
    multi     = 1'b0;
    acc       = 1'b0;

    odata_nxt = odata_r;
    odv_nxt   = odv_r;
    olast_nxt = olast_r;
    oacc_nxt  = oacc_r;
    ostat_nxt = ostat_r;
    ovalid_nxt = out_ch.ready ? 1'b0 : ovalid_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_ch.cmd) inside
            CMD_WRITE: begin
              if (!done_r && (fill_r < eff_cap)) begin
                ram_we   = 1'b1;
                fill_nxt = fill_r + 1'b1;
                wtot_nxt = wtot_r + 1'b1;
                acc      = 1'b1;
              end
            end
            CMD_READ, CMD_POP: begin
              if (run_ext > fill_r) begin
                err_nxt = 1'b1;
              end else if (run_sat != '0) begin
                head_nxt = (psum >= DEPTH_S) ? AW'(psum - DEPTH_S) : AW'(psum);
                fill_nxt = fill_r - run_ext;
                rtot_nxt = rtot_r + TOT_W'(run_sat);
                if (in_ch.cmd == CMD_READ) begin
                  ram_re    = 1'b1;
                  ptr_nxt   = ptr_inc(head_r);
                  left_nxt  = run_sat - 1'b1;
                  state_nxt = ST_RUN;
                  multi     = 1'b1;
                end else begin
                  acc = 1'b1;
                end
              end
            end
            CMD_PEEK: begin
              if (peek_n != '0) begin
                ram_re    = 1'b1;
                ptr_nxt   = ptr_inc(head_r);
                left_nxt  = peek_n - 1'b1;
                state_nxt = ST_RUN;
                multi     = 1'b1;
              end else begin
                acc = 1'b1;
              end
            end
            CMD_END: begin
              done_nxt = 1'b1;
              acc      = 1'b1;
            end
            default: begin
            end
          endcase

          // Single status word for every command that streams no bytes
          if (!multi) begin
            ovalid_nxt = 1'b1;
            odata_nxt  = '0;
            odv_nxt    = 1'b0;
            olast_nxt  = 1'b1;
            oacc_nxt   = acc;
            ostat_nxt  = make_stat(fill_nxt, done_nxt, err_nxt, wtot_nxt, rtot_nxt, eff_cap);
          end
        end
      end
      ST_RUN: begin
        // Move the pending byte out and, while bytes remain, fetch the next one
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = ram_rdata;
          odv_nxt    = 1'b1;
          olast_nxt  = (left_r == '0);
          oacc_nxt   = 1'b1;
          ostat_nxt  = make_stat(fill_r, done_r, err_r, wtot_r, rtot_r, eff_cap);
          if (left_r != '0) begin
            ram_re    = 1'b1;
            ram_raddr = ptr_r;
            ptr_nxt   = ptr_inc(ptr_r);
            left_nxt  = left_r - 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      head_r   <= '0;
      fill_r   <= '0;
      done_r   <= 1'b0;
      err_r    <= 1'b0;
      wtot_r   <= '0;
      rtot_r   <= '0;
      cap_r    <= CAP_RESET;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      fill_r   <= fill_nxt;
      done_r   <= done_nxt;
      err_r    <= err_nxt;
      wtot_r   <= wtot_nxt;
      rtot_r   <= rtot_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Run pointer and output payload
  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    left_r  <= left_nxt;
    odata_r <= odata_nxt;
    odv_r   <= odv_nxt;
    olast_r <= olast_nxt;
    oacc_r  <= oacc_nxt;
    ostat_r <= ostat_nxt;
  end

  assign out_ch.valid         = ovalid_r;
  assign out_ch.data_out      = odata_r;
  assign out_ch.data_valid    = odv_r;
  assign out_ch.last          = olast_r;
  assign out_ch.accepted      = oacc_r;
  assign out_ch.error_flag    = ostat_r.error_flag;
  assign out_ch.buffered      = ostat_r.buffered;
  assign out_ch.space_left    = ostat_r.space_left;
  assign out_ch.ended         = ostat_r.ended;
  assign out_ch.at_eof        = ostat_r.at_eof;
  assign out_ch.total_written = ostat_r.total_written;
  assign out_ch.total_read    = ostat_r.total_read;

endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
  import bbsf_pkg::*;

  localparam int DEPTH = DEF_DEPTH;
  localparam int MAX_RUN = DEF_MAX_RUN;
  // highest code the command field can carry; codes above CMD_END are unused
  localparam logic [CMD_W-1:0] CMD_TOP = 3'd7;
  localparam int LONG_STALL = 300;
  localparam int SETTLE_CYCLES = 3;
  localparam int TAIL_CYCLES = 10;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              dvalid;
    logic              last;
    logic              acc;
    stat_t             st;
  } fifo_word_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data;
    logic [RUN_W-1:0]  run;
  } fifo_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  // pacing controls: quiet is shared by the driver and the receiver, the stall pair serves the receiver
  logic quiet = 1'b0;
  logic stall_req = 1'b0;
  logic stall_taken = 1'b0;

  bbsf_in_if  in_ch();
  bbsf_out_if out_ch();

  bounded_byte_stream_fifo_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #1 clk = ~clk;

  // Shadow copy of the stream state
  logic [BYTE_W-1:0] mem_m [DEPTH];
  int                head_m = 0;
  int                fill_m = 0;
  logic              done_m = 1'b0;
  logic              err_m = 1'b0;
  logic [TOT_W-1:0]  wtot_m = '0;
  logic [TOT_W-1:0]  rtot_m = '0;
  logic [CAP_W-1:0]  cap_m = CAP_RESET;

  fifo_cmd_t  cmd_q[$];
  fifo_word_t word_q[$];
  int         queued_n = 0;
  int         taken_n = 0;
  int         mismatch_n = 0;

  fifo_cmd_t  tx_cur;
  int         tx_gap = 0;
  int         rx_gap = 0;
  int         hold_left = 0;
  fifo_word_t mon_got;
  fifo_word_t mon_want;

  function automatic int eff_cap();
    return (int'(cap_m) < DEPTH) ? int'(cap_m) : DEPTH;
  endfunction

  // Build a result word carrying the stream status as it stands now
  function automatic fifo_word_t status_word(logic [BYTE_W-1:0] b, logic dv, logic lst,
                                             logic acc);
    fifo_word_t w;
    int         cap;
    cap = eff_cap();
    w.data_byte        = b;
    w.dvalid           = dv;
    w.last             = lst;
    w.acc              = acc;
    w.st.error_flag    = err_m;
    w.st.buffered      = CAP_W'(fill_m);
    w.st.space_left    = CAP_W'((cap > fill_m) ? cap - fill_m : 0);
    w.st.ended         = done_m;
    w.st.at_eof        = done_m && (fill_m == 0);
    w.st.total_written = wtot_m;
    w.st.total_read    = rtot_m;
    return w;
  endfunction

  // Append a word to the expected results
  function automatic void add_word(fifo_word_t w);
    word_q = {word_q, w};
  endfunction

  // Advance the shadow state by one command and queue the words it yields
  task automatic apply_cmd(fifo_cmd_t c);
    logic [BYTE_W-1:0] grab [MAX_RUN];
    int                run;
    int                n;
    int                i;
    run = (int'(c.run) > MAX_RUN) ? MAX_RUN : int'(c.run);
    case (c.cmd)
      CMD_WRITE: begin
        if (!done_m && fill_m < eff_cap()) begin
          mem_m[(head_m + fill_m) % DEPTH] = c.data;
          fill_m++;
          wtot_m++;
          add_word(status_word('0, 1'b0, 1'b1, 1'b1));
        end else begin
          add_word(status_word('0, 1'b0, 1'b1, 1'b0));
        end
      end
      CMD_READ, CMD_POP: begin
        if (run > fill_m) begin
          err_m = 1'b1;
          add_word(status_word('0, 1'b0, 1'b1, 1'b0));
        end else if (run == 0) begin
          add_word(status_word('0, 1'b0, 1'b1, 1'b0));
        end else begin
          for (i = 0; i < run; i++) grab[i] = mem_m[(head_m + i) % DEPTH];
          head_m = (head_m + run) % DEPTH;
          fill_m -= run;
          rtot_m += TOT_W'(run);
          if (c.cmd == CMD_READ) begin
            for (i = 0; i < run; i++)
              add_word(status_word(grab[i], 1'b1, i == run - 1, 1'b1));
          end else begin
            add_word(status_word('0, 1'b0, 1'b1, 1'b1));
          end
        end
      end
      CMD_PEEK: begin
        n = (run < fill_m) ? run : fill_m;
        if (n == 0) begin
          add_word(status_word('0, 1'b0, 1'b1, 1'b1));
        end else begin
          for (i = 0; i < n; i++)
            add_word(status_word(mem_m[(head_m + i) % DEPTH], 1'b1, i == n - 1, 1'b1));
        end
      end
      CMD_END: begin
        done_m = 1'b1;
        add_word(status_word('0, 1'b0, 1'b1, 1'b1));
      end
      default: begin
        add_word(status_word('0, 1'b0, 1'b1, 1'b0));
      end
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic string fmt_word(fifo_word_t w);
    return {$sformatf("byte %h dv %b last %b acc %b err %b ",
                      w.data_byte, w.dvalid, w.last, w.acc, w.st.error_flag),
            $sformatf("buf %0d space %0d ended %b eof %b wr %0d rd %0d",
                      w.st.buffered, w.st.space_left, w.st.ended, w.st.at_eof,
                      w.st.total_written, w.st.total_read)};
  endfunction

  task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                           logic [RUN_W-1:0] run);
    fifo_cmd_t c;
    c.cmd  = cmd;
    c.data = data;
    c.run  = run;
    cmd_q = {cmd_q, c};
    queued_n++;
  endtask

  // Random commands: short runs with a long_pct share of long ones, rare unknown codes
  task automatic queue_random(int count, int write_pct, int long_pct, int end_pct);
    int               roll;
    logic [CMD_W-1:0] cmd;
    logic [RUN_W-1:0] run;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      run = RUN_W'($urandom_range(0, 12));
      if ($urandom_range(0, 99) < long_pct) run = RUN_W'($urandom_range(0, 127));
      if (roll < end_pct) cmd = CMD_END;
      else if (roll < end_pct + 3) cmd = CMD_W'($urandom_range(CMD_END + 1, CMD_TOP));
      else if (roll < write_pct) cmd = CMD_WRITE;
      else cmd = CMD_W'($urandom_range(CMD_READ, CMD_PEEK));
      queue_cmd(cmd, BYTE_W'($urandom_range(0, 255)), run);
    end
  endtask

  // Hold until every queued command is taken and every result word has come
  task automatic wait_idle();
    while (taken_n != queued_n || word_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    cap_m = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_cmd(tx_cur);
        taken_n++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_ch.valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          tx_cur = cmd_q[0];
          cmd_q.delete(0);
          in_ch.cmd <= tx_cur.cmd;
          in_ch.data_in <= tx_cur.data;
          in_ch.run_length <= tx_cur.run;
          in_ch.valid <= 1'b1;
          tx_gap = quiet ? 0 : pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random back-pressure plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_gap = 0;
      hold_left = 0;
    end else if (stall_req && !stall_taken) begin
      stall_taken = 1'b1;
      hold_left = LONG_STALL;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      rx_gap = quiet ? 0 : pick_gap();
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      mon_got.data_byte        = out_ch.data_out;
      mon_got.dvalid           = out_ch.data_valid;
      mon_got.last             = out_ch.last;
      mon_got.acc              = out_ch.accepted;
      mon_got.st.error_flag    = out_ch.error_flag;
      mon_got.st.buffered      = out_ch.buffered;
      mon_got.st.space_left    = out_ch.space_left;
      mon_got.st.ended         = out_ch.ended;
      mon_got.st.at_eof        = out_ch.at_eof;
      mon_got.st.total_written = out_ch.total_written;
      mon_got.st.total_read    = out_ch.total_read;
      if (word_q.size() == 0) begin
        mismatch_n++;
        if (mismatch_n <= MAX_REPORTS)
          $display("%0t: unexpected word: %s", $realtime, fmt_word(mon_got));
      end else begin
        mon_want = word_q[0];
        word_q.delete(0);
        if (mon_got.data_byte !== mon_want.data_byte || mon_got.dvalid !== mon_want.dvalid ||
            mon_got.last !== mon_want.last || mon_got.acc !== mon_want.acc ||
            mon_got.st.error_flag !== mon_want.st.error_flag ||
            mon_got.st.buffered !== mon_want.st.buffered ||
            mon_got.st.space_left !== mon_want.st.space_left ||
            mon_got.st.ended !== mon_want.st.ended ||
            mon_got.st.at_eof !== mon_want.st.at_eof ||
            mon_got.st.total_written !== mon_want.st.total_written ||
            mon_got.st.total_read !== mon_want.st.total_read) begin
          mismatch_n++;
          if (mismatch_n <= MAX_REPORTS) begin
            $display("%0t: word mismatch", $realtime);
            $display("  expected %s", fmt_word(mon_want));
            $display("  actual   %s", fmt_word(mon_got));
          end
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    int c;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_WRITE;
    in_ch.data_in = '0;
    in_ch.run_length = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: tiny capacity, empty-store corners, refusals, long and odd runs
    set_capacity(9'd4);
    queue_cmd(CMD_PEEK, 8'h00, 7'd5);
    queue_cmd(CMD_READ, 8'h00, 7'd0);
    queue_cmd(CMD_POP, 8'h00, 7'd0);
    queue_cmd(CMD_READ, 8'h00, 7'd3);
    queue_cmd(CMD_WRITE, 8'h00, 7'd0);
    queue_cmd(CMD_WRITE, 8'hFF, 7'd0);
    queue_cmd(CMD_WRITE, 8'hA5, 7'd0);
    queue_cmd(CMD_WRITE, 8'h5A, 7'd0);
    queue_cmd(CMD_WRITE, 8'h11, 7'd0);
    queue_cmd(CMD_PEEK, 8'h00, 7'h7F);
    for (c = CMD_END + 1; c <= CMD_TOP; c++) queue_cmd(CMD_W'(c), 8'hFF, 7'h7F);
    queue_cmd(CMD_READ, 8'h00, 7'd2);
    queue_cmd(CMD_POP, 8'h00, 7'd1);
    queue_cmd(CMD_POP, 8'h00, 7'd5);
    queue_cmd(CMD_READ, 8'h00, 7'd64);
    wait_idle();

    // Fill to full depth; the receiver holds off once at the start
    set_capacity(CAP_RESET);
    stall_req = 1'b1;
    repeat (DEPTH + 6) queue_cmd(CMD_WRITE, BYTE_W'($urandom_range(0, 255)), 7'd0);
    wait_idle();

    // Drop capacity below the fill level and drain with long runs
    set_capacity(9'd0);
    queue_random(20, 20, 60, 0);
    wait_idle();

    // Back-to-back traffic with no idling
    set_capacity(9'd255);
    quiet = 1'b1;
    queue_random(15, 50, 30, 0);
    wait_idle();
    quiet = 1'b0;

    set_capacity(9'd9);
    queue_random(15, 60, 10, 0);
    wait_idle();

    set_capacity(9'd1);
    queue_random(10, 50, 10, 0);
    wait_idle();

    set_capacity(9'd64);
    queue_random(15, 55, 20, 0);
    wait_idle();

    // End of input, refused writes after it, then drain to end of stream
    set_capacity(CAP_RESET);
    queue_random(10, 60, 10, 0);
    queue_cmd(CMD_END, 8'h00, 7'd0);
    queue_cmd(CMD_WRITE, 8'h33, 7'd0);
    queue_cmd(CMD_END, 8'h00, 7'd0);
    queue_random(10, 30, 20, 5);
    wait_idle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_n == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[bounded_byte_stream_fifo_top.f]
rtl/bbsf_pkg.sv
rtl/bbsf_in_if.sv
rtl/bbsf_out_if.sv
rtl/bbsf_ram.sv
rtl/bounded_byte_stream_fifo_top.sv
dv/tb.sv
